// ===== rtl/sbrm_pkg.sv =====
`timescale 1ns / 1ps
package sbrm_pkg;

	localparam int MAX_PHASES_DEF  = 8;
	localparam int COLUMN_BITS_DEF = 10;

	localparam int PHASE_FIELDS = 8;
	localparam int PF_IDX_W     = 3;
	localparam int TIME_W       = 16;
	localparam int SCALE_W      = 16;
	localparam int PROD_W       = TIME_W + SCALE_W;
	localparam int PX_W         = 10;
	localparam int TRACK_W      = 4;
	localparam int PC_W         = 4;

	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32'h0000_8000);

	localparam int IN_DATA_W  = (PHASE_FIELDS + 1) * TIME_W;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_PAD_W  = OUT_DATA_W - TRACK_W - 3 * PX_W;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_PHASES_USED  = 2'd0,
		REG_GRAPH_HEIGHT = 2'd1,
		REG_TIME_SCALE   = 2'd2,
		REG_GRAPH_WIDTH  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [PC_W-1:0]    phases_used;
		logic [PX_W-1:0]    graph_height;
		logic [SCALE_W-1:0] time_scale;
		logic [PX_W-1:0]    graph_width;
	} cfg_t;

	// one track step of an item; last marks the frame line track
	typedef struct packed {
		logic               flush;
		logic               last;
		logic [TRACK_W-1:0] track;
		logic [PX_W-1:0]    value;
	} entry_t;

	typedef struct packed {
		logic [TRACK_W-1:0] track;
		logic               frame_line;
		logic [PX_W-1:0]    start_column;
		logic [PX_W-1:0]    end_column;
		logic [PX_W-1:0]    bar_height;
	} rect_t;

endpackage

// ===== rtl/sbrm_front.sv =====
`timescale 1ns / 1ps
module sbrm_front #(
	parameter int MAX_PHASES = sbrm_pkg::MAX_PHASES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sbrm_pkg::cfg_t                 cfg,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sbrm_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	output logic                           push,
	output sbrm_pkg::entry_t               push_entry,
	input  logic                           full
);

	localparam logic [sbrm_pkg::PC_W-1:0] PC_MAX = sbrm_pkg::PC_W'(MAX_PHASES);
	localparam logic [sbrm_pkg::PROD_W-1:0] ROUND_HALF_C = sbrm_pkg::ROUND_HALF;

	logic [sbrm_pkg::PC_W-1:0]    pc;
	logic                         busy_q;
	logic                         flush_q;
	logic [sbrm_pkg::TIME_W-1:0]  times_q [sbrm_pkg::PHASE_FIELDS];
	logic [sbrm_pkg::TIME_W-1:0]  frame_q;
	logic [sbrm_pkg::TRACK_W-1:0] t_q;
	logic [sbrm_pkg::TIME_W-1:0]  time_sel;
	logic                         advance;
	logic                         issue;
	logic                         accept;

	logic                         s1_v_q;
	logic [sbrm_pkg::PROD_W-1:0]  prod_s1;
	logic [sbrm_pkg::TRACK_W-1:0] track_s1;
	logic                         first_s1;
	logic                         last_s1;
	logic                         flush_s1;

	logic [sbrm_pkg::PX_W-1:0]    total_q;
	logic [sbrm_pkg::PROD_W-1:0]  rounded;
	logic [sbrm_pkg::TIME_W-1:0]  h;
	logic [sbrm_pkg::PX_W-1:0]    base;
	logic [sbrm_pkg::PX_W-1:0]    room;
	logic [sbrm_pkg::PX_W-1:0]    value;

	assign pc       = (cfg.phases_used > PC_MAX) ? PC_MAX : cfg.phases_used;
	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign advance  = !s1_v_q || push;
	assign issue    = busy_q && advance;
	assign time_sel = (t_q == pc) ? frame_q : times_q[t_q[sbrm_pkg::PF_IDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			t_q    <= '0;
			s1_v_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				t_q    <= '0;
			end else if (issue) begin
				if (t_q == pc) begin
					busy_q <= 1'b0;
				end else begin
					t_q <= t_q + 1'b1;
				end
			end
			if (issue) begin
				s1_v_q <= 1'b1;
			end else if (push) begin
				s1_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flush_q <= s_tuser;
			for (int i = 0; i < sbrm_pkg::PHASE_FIELDS; i++) begin
				times_q[i] <= s_tdata[i*sbrm_pkg::TIME_W +: sbrm_pkg::TIME_W];
			end
			frame_q <= s_tdata[sbrm_pkg::PHASE_FIELDS*sbrm_pkg::TIME_W +: sbrm_pkg::TIME_W];
		end
		if (issue) begin
			prod_s1  <= sbrm_pkg::PROD_W'(time_sel) * sbrm_pkg::PROD_W'(cfg.time_scale);
			track_s1 <= t_q;
			first_s1 <= (t_q == '0);
			last_s1  <= (t_q == pc);
			flush_s1 <= flush_q;
		end
		if (push && !last_s1) begin
			total_q <= value;
		end
	end

	// round half up, then stack (all but the frame line track) and clamp to the graph height
	always_comb begin
		rounded = prod_s1 + ROUND_HALF_C;
		h       = rounded[sbrm_pkg::PROD_W-1 -: sbrm_pkg::TIME_W];
		base    = first_s1 ? '0 : total_q;
		room    = cfg.graph_height - base;
		if (last_s1) begin
			value = (h > sbrm_pkg::TIME_W'(cfg.graph_height)) ? cfg.graph_height
				: h[sbrm_pkg::PX_W-1:0];
		end else begin
			value = base + ((h > sbrm_pkg::TIME_W'(room)) ? room : h[sbrm_pkg::PX_W-1:0]);
		end
	end

	assign push             = s1_v_q && !full;
	assign push_entry.flush = flush_s1;
	assign push_entry.last  = last_s1;
	assign push_entry.track = track_s1;
	assign push_entry.value = value;

`ifndef ASSERT_OFF
	a_track_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> t_q <= pc)
		else $error("track counter ran past the phase count");
`endif

endmodule

// ===== rtl/sbrm_queue.sv =====
`timescale 1ns / 1ps
module sbrm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sbrm_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output sbrm_pkg::entry_t head
);

	sbrm_pkg::entry_t             mem_q [sbrm_pkg::Q_DEPTH];
	logic [sbrm_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [sbrm_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [sbrm_pkg::Q_CNT_W-1:0] count_q;

	assign full       = (count_q == sbrm_pkg::Q_CNT_W'(sbrm_pkg::Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== rtl/sbrm_back.sv =====
`timescale 1ns / 1ps
module sbrm_back #(
	parameter int MAX_PHASES  = sbrm_pkg::MAX_PHASES_DEF,
	parameter int COLUMN_BITS = sbrm_pkg::COLUMN_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sbrm_pkg::cfg_t   cfg,
	input  logic             head_valid,
	input  sbrm_pkg::entry_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output sbrm_pkg::rect_t  out_rect,
	output logic             out_last
);

	localparam int TRACKS = MAX_PHASES + 1;
	localparam int TIDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};
	localparam logic [COLUMN_BITS-1:0] COL_ONE = COLUMN_BITS'(1);

	logic [sbrm_pkg::PX_W-1:0] run_height_q [TRACKS];
	logic [COLUMN_BITS-1:0]    seg_start_q  [TRACKS];
	logic                      hist_open_q;
	logic [COLUMN_BITS-1:0]    column_q;

	logic                      pend_v_q;
	logic                      pend_last_q;
	sbrm_pkg::rect_t           pend_q;
	logic                      out_v_q;
	sbrm_pkg::rect_t           out_q;
	logic                      out_last_q;

	logic [TIDX_W-1:0]         idx;
	logic [sbrm_pkg::PX_W-1:0] rh;
	logic                      rect_hit;
	sbrm_pkg::rect_t           new_rect;
	logic                      out_free;
	logic                      hold;
	logic                      need_move;
	logic                      drain;
	logic                      out_load;

	assign idx       = head.track[TIDX_W-1:0];
	assign rh        = run_height_q[idx];
	assign rect_hit  = hist_open_q && (rh != '0) && (head.flush || (head.value != rh));
	assign out_free  = !out_v_q || out_ready;
	assign hold      = pend_v_q && pend_last_q;
	assign need_move = pend_v_q && (rect_hit || head.last);
	assign pop       = head_valid && !hold && (!need_move || out_free);
	assign drain     = hold && out_free;
	assign out_load  = (pop && need_move) || drain;

	always_comb begin
		new_rect.track        = head.track;
		new_rect.frame_line   = head.last;
		new_rect.start_column = sbrm_pkg::PX_W'(seg_start_q[idx]);
		new_rect.end_column   = head.flush ? cfg.graph_width : sbrm_pkg::PX_W'(column_q);
		new_rect.bar_height   = rh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRACKS; i++) begin
				run_height_q[i] <= '0;
				seg_start_q[i]  <= '0;
			end
			hist_open_q <= 1'b0;
			column_q    <= COL_ONE;
			pend_v_q    <= 1'b0;
			pend_last_q <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (pop) begin
				if (head.flush) begin
					if (head.last) begin
						for (int i = 0; i < TRACKS; i++) begin
							run_height_q[i] <= '0;
							seg_start_q[i]  <= '0;
						end
						hist_open_q <= 1'b0;
						column_q    <= COL_ONE;
					end
				end else begin
					if (!hist_open_q || (head.value != rh)) begin
						run_height_q[idx] <= head.value;
						seg_start_q[idx]  <= column_q;
					end
					if (head.last) begin
						hist_open_q <= 1'b1;
						if (column_q != COL_MAX) begin
							column_q <= column_q + 1'b1;
						end
					end
				end
				if (rect_hit) begin
					pend_v_q    <= 1'b1;
					pend_last_q <= head.last;
				end else if (head.last) begin
					pend_v_q <= 1'b0;
				end
			end else if (drain) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// a rectangle waits in pend_q until the next one or the item end decides tlast
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q      <= pend_q;
			out_last_q <= drain || (pop && !rect_hit && head.last);
		end
		if (pop && rect_hit) begin
			pend_q <= new_rect;
		end
	end

	assign out_valid = out_v_q;
	assign out_rect  = out_q;
	assign out_last  = out_last_q;

`ifndef ASSERT_OFF
	a_height_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> out_q.bar_height != '0)
		else $error("zero height rectangle sent");

	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && pend_last_q) |-> !pop)
		else $error("queue popped while a closing rectangle is pending");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.flush && head.last) |=> (!hist_open_q && column_q == COL_ONE))
		else $error("flush did not restart the history");

	a_no_pend_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && need_move) |-> out_free)
		else $error("pending rectangle overwritten");
`endif

endmodule

// ===== rtl/stacked_bar_run_merger.sv =====
`timescale 1ns / 1ps
// Stacked bar run merger.
// Slave channel s_*: one word per timing sample or flush. s_tuser is the opcode
// (0 sample, 1 flush); s_tdata holds phase_time_0..7 and frame_time, Q8.8 ms.
// Master channel m_*: one word per rectangle; m_tlast marks the final rectangle
// caused by an input word, m_tuser flags the frame line.
// Configuration: cfg_we writes cfg_data into register cfg_addr (0 phases in use,
// 1 graph_height, 2 time_scale, 3 graph_width); write only while idle.
// Throughput: the front end walks a word's tracks through the single shared
// 16x16 scaling multiplier one per cycle while the queue is not full, and takes
// the next word once its last track is issued. Rectangles leave at most one per cycle.
// A track's product passes from its product register through the queue and pend_q
// into out_q before m_tvalid rises; a rectangle is held in pend_q until the next
// rectangle or the word's last track settles m_tlast.
// A four-entry queue parts the scaler from the run tracker, so a stalled
// m_tready backs up the queue and only then the slave side.
// Reset clears all runs, sets the column to 1 and loads the register defaults
// (1 phase, graph_height 100, time_scale 1.0, graph_width 256).
module stacked_bar_run_merger #(
	parameter int MAX_PHASES  = sbrm_pkg::MAX_PHASES_DEF,
	parameter int COLUMN_BITS = sbrm_pkg::COLUMN_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sbrm_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [sbrm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// phase_time_0 .. phase_time_7, frame_time
	input  logic [sbrm_pkg::IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// track, start_column, end_column, bar_height, zero pad
	output logic [sbrm_pkg::OUT_DATA_W-1:0] m_tdata,
	// frame_line
	output logic                            m_tuser,
	output logic                            m_tlast
);

	sbrm_pkg::cfg_t   cfg_q;
	logic             push;
	sbrm_pkg::entry_t push_entry;
	logic             full;
	logic             pop;
	logic             head_valid;
	sbrm_pkg::entry_t head;
	sbrm_pkg::rect_t  out_rect;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phases_used  <= sbrm_pkg::PC_W'(1);
			cfg_q.graph_height <= sbrm_pkg::PX_W'(100);
			cfg_q.time_scale   <= sbrm_pkg::SCALE_W'(256);
			cfg_q.graph_width  <= sbrm_pkg::PX_W'(256);
		end else if (cfg_we) begin
			case (sbrm_pkg::cfg_reg_t'(cfg_addr))
				sbrm_pkg::REG_PHASES_USED:  cfg_q.phases_used  <= cfg_data[sbrm_pkg::PC_W-1:0];
				sbrm_pkg::REG_GRAPH_HEIGHT: cfg_q.graph_height <= cfg_data[sbrm_pkg::PX_W-1:0];
				sbrm_pkg::REG_TIME_SCALE:   cfg_q.time_scale   <= cfg_data[sbrm_pkg::SCALE_W-1:0];
				sbrm_pkg::REG_GRAPH_WIDTH:  cfg_q.graph_width  <= cfg_data[sbrm_pkg::PX_W-1:0];
				default: ;
			endcase
		end
	end

	sbrm_front #(
		.MAX_PHASES(MAX_PHASES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_entry(push_entry),
		.full      (full)
	);

	sbrm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	sbrm_back #(
		.MAX_PHASES (MAX_PHASES),
		.COLUMN_BITS(COLUMN_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rect  (out_rect),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{sbrm_pkg::OUT_PAD_W{1'b0}}, out_rect.bar_height, out_rect.end_column,
		out_rect.start_column, out_rect.track};
	assign m_tuser = out_rect.frame_line;

endmodule
